// ===== src/rclpt_pkg.sv =====
// ----------------------------------------------------------------------------
// rclpt_pkg
// Shared types, constants and the slot hash multipliers for the reference-counted
// linear-probe table.
// ----------------------------------------------------------------------------
package rclpt_pkg;

  localparam int unsigned TableEntries = 256;
  localparam int unsigned SlotBits     = $clog2(TableEntries);
  localparam int unsigned CountBits    = 16;
  localparam int unsigned TagBits      = 16;

  localparam logic [63:0] HashMulA = 64'hff51afd7ed558ccd;
  localparam logic [63:0] HashMulB = 64'hc4ceb9fe1a85ec53;
  localparam int unsigned HashShift = 33;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StFull      = 3'd1,
    StNotFound  = 3'd2,
    StKeyZero   = 3'd3,
    StSaturated = 3'd4
  } status_e;

  typedef enum logic {
    OpAcquire = 1'b0,
    OpRelease = 1'b1
  } op_e;

  typedef struct packed {
    logic        op;
    logic [63:0] key;
    logic [15:0] buffer_tag;
    logic        write_back_request;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  slot;
    logic [15:0] count_after;
    logic        entry_freed;
    logic        free_memory;
    logic [15:0] freed_buffer_tag;
    logic        do_write_back;
    logic        release_buffer;
  } rsp_t;

  typedef struct packed {
    logic [63:0]          key;
    logic [CountBits-1:0] count;
    logic [TagBits-1:0]   tag;
  } entry_t;

  // Hash unit control between the sequencer and the hash unit.
  typedef struct packed {
    logic        start;
    logic [63:0] key;
  } hash_req_t;

  typedef struct packed {
    logic                done;
    logic [SlotBits-1:0] home;
  } hash_rsp_t;

endpackage

// ===== src/refcounted_linear_probe_table.sv =====
// ----------------------------------------------------------------------------
// refcounted_linear_probe_table
// Reference-counted open-addressing table with linear probing and
// backward-shift deletion, held in one synchronous slot memory.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake           Payload
// req       in   req_valid_i/ready_o  req_i (req_t)
// rsp       out  rsp_valid_o/ready_i  rsp_o (rsp_t)
//
// One item at a time: it is taken, hashed, the slots are probed in turn and
// the result is posted. A removal then walks the occupied slots in compaction,
// moving entries back where they may, up to the empty slot at the end.
// After reset a clearing pass empties all 256 slots of the memory; no item is
// accepted until it ends. A stalled result holds in the output register
// while the next item is already accepted.
// ----------------------------------------------------------------------------
module refcounted_linear_probe_table import rclpt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  localparam logic [3:0] SClear   = 4'd0;
  localparam logic [3:0] SIdle    = 4'd1;
  localparam logic [3:0] SHash    = 4'd2;
  localparam logic [3:0] SRead    = 4'd3;
  localparam logic [3:0] SCheck   = 4'd4;
  localparam logic [3:0] SResult  = 4'd5;
  localparam logic [3:0] SShRead  = 4'd6;
  localparam logic [3:0] SShCheck = 4'd7;
  localparam logic [3:0] SShHash  = 4'd8;
  localparam logic [3:0] SShMove  = 4'd9;

  localparam logic [CountBits-1:0] CountMax = '1;

  logic [3:0] state_q, state_d;

  // Slot memory.
  entry_t              mem_q [TableEntries];
  logic                mem_we;
  logic [SlotBits-1:0] mem_waddr;
  entry_t              mem_wdata;
  logic [SlotBits-1:0] mem_raddr;
  entry_t              rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  req_t                req_q, req_d;
  logic [SlotBits-1:0] pos_q, pos_d;
  logic [SlotBits-1:0] hole_q, hole_d;
  logic [SlotBits:0]   cnt_q, cnt_d;
  entry_t              ent_q, ent_d;
  rsp_t                res_q, res_d;
  rsp_t                out_q;
  logic                out_valid_q;
  logic                res_push;

  hash_req_t hreq;
  hash_rsp_t hrsp;

  rclpt_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hreq),
    .rsp_o  (hrsp)
  );

  logic [SlotBits-1:0] probe_dist, gap;
  logic [TagBits-1:0]  tag_in;
  logic [TagBits-1:0]  ftag;

  assign tag_in     = req_q.buffer_tag[TagBits-1:0];
  assign probe_dist = pos_q - hrsp.home;
  assign gap        = pos_q - hole_q;
  assign ftag       = ent_q.tag;

  assign req_ready_o = (state_q == SIdle);

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    pos_d     = pos_q;
    hole_d    = hole_q;
    cnt_d     = cnt_q;
    ent_d     = ent_q;
    res_d     = res_q;
    res_push  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pos_q;
    mem_wdata = rdata_q;
    mem_raddr = pos_q;
    hreq.start = 1'b0;
    hreq.key   = req_q.key;
    case (state_q)
      SClear: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[SlotBits-1:0];
        mem_wdata = '0;
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == (SlotBits+1)'(TableEntries - 1)) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (req_valid_i) begin
          req_d = req_i;
          res_d = '0;
          if (req_i.key == '0) begin
            res_d.status = StKeyZero;
            state_d      = SResult;
          end else begin
            hreq.start = 1'b1;
            hreq.key   = req_i.key;
            state_d    = SHash;
          end
        end
      end
      SHash: begin
        if (hrsp.done) begin
          pos_d   = hrsp.home;
          cnt_d   = '0;
          state_d = SRead;
        end
      end
      SRead: begin
        mem_raddr = pos_q;
        state_d   = SCheck;
      end
      SCheck: begin
        if (rdata_q.key == req_q.key) begin
          res_d.slot = 8'(pos_q);
          if (req_q.op == OpAcquire) begin
            if (rdata_q.count >= CountMax) begin
              res_d.status      = StSaturated;
              res_d.count_after = 16'(rdata_q.count);
            end else begin
              mem_we            = 1'b1;
              mem_wdata         = rdata_q;
              mem_wdata.count   = rdata_q.count + 1'b1;
              res_d.count_after = 16'(rdata_q.count + 1'b1);
            end
            state_d = SResult;
          end else if (rdata_q.count > CountBits'(1)) begin
            mem_we            = 1'b1;
            mem_wdata         = rdata_q;
            mem_wdata.count   = rdata_q.count - 1'b1;
            res_d.count_after = 16'(rdata_q.count - 1'b1);
            state_d           = SResult;
          end else begin
            ent_d     = rdata_q;
            mem_we    = 1'b1;
            mem_wdata = '0;
            hole_d    = pos_q;
            pos_d     = pos_q + 1'b1;
            cnt_d     = '0;
            state_d   = SShRead;
          end
        end else if (rdata_q.key == '0) begin
          if (req_q.op == OpAcquire) begin
            mem_we            = 1'b1;
            mem_wdata.key     = req_q.key;
            mem_wdata.tag     = tag_in;
            mem_wdata.count   = CountBits'(1);
            res_d.slot        = 8'(pos_q);
            res_d.count_after = 16'd1;
          end else begin
            res_d.status = StNotFound;
          end
          state_d = SResult;
        end else if (cnt_q == (SlotBits+1)'(TableEntries - 1)) begin
          res_d.status = (req_q.op == OpAcquire) ? StFull : StNotFound;
          state_d      = SResult;
        end else begin
          pos_d   = pos_q + 1'b1;
          cnt_d   = cnt_q + 1'b1;
          state_d = SRead;
        end
      end
      SShRead: begin
        mem_raddr = pos_q;
        state_d   = SShCheck;
      end
      SShCheck: begin
        if (rdata_q.key == '0 || cnt_q == (SlotBits+1)'(TableEntries)) begin
          res_d.entry_freed      = 1'b1;
          res_d.free_memory      = (ftag == '0);
          res_d.freed_buffer_tag = 16'(ftag);
          res_d.do_write_back    = (ftag != '0) && req_q.write_back_request;
          res_d.release_buffer   = (ftag != '0);
          state_d                = SResult;
        end else begin
          req_d.buffer_tag = req_q.buffer_tag;
          hreq.start       = 1'b1;
          hreq.key         = rdata_q.key;
          state_d          = SShHash;
        end
      end
      SShHash: begin
        if (hrsp.done) begin
          state_d = SShMove;
        end
      end
      SShMove: begin
        // Read data still holds the entry at pos_q.
        if (probe_dist >= gap) begin
          mem_we    = 1'b1;
          mem_waddr = hole_q;
          mem_wdata = rdata_q;
          hole_d    = pos_q;
          state_d   = SShMove;
          // Clear the moved-from slot in the following pass.
          cnt_d     = cnt_q;
          ent_d     = ent_q;
        end
        if (probe_dist >= gap) begin
          state_d = SShRead;
          pos_d   = pos_q;
          ent_d   = ent_q;
        end else begin
          pos_d   = pos_q + 1'b1;
          cnt_d   = cnt_q + 1'b1;
          state_d = SShRead;
        end
      end
      SResult: begin
        if (!out_valid_q || rsp_ready_i) begin
          res_push = 1'b1;
          state_d  = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
    // A moved entry leaves its old slot empty; pos_q equals the new hole.
    if (state_q == SShRead && pos_q == hole_q) begin
      mem_we    = 1'b1;
      mem_waddr = pos_q;
      mem_wdata = '0;
      pos_d     = pos_q + 1'b1;
      cnt_d     = cnt_q + 1'b1;
      state_d   = SShRead;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (res_push) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    pos_q  <= pos_d;
    hole_q <= hole_d;
    ent_q  <= ent_d;
    res_q  <= res_d;
    if (res_push) begin
      out_q <= res_d;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

  property p_no_accept_while_busy;
    @(posedge clk_i) disable iff (!rst_ni)
      (req_valid_i && req_ready_o) |=> !req_ready_o;
  endproperty
  assert property (p_no_accept_while_busy) else $error("accept while busy");

  property p_push_only_when_free;
    @(posedge clk_i) disable iff (!rst_ni)
      res_push |-> (!out_valid_q || rsp_ready_i);
  endproperty
  assert property (p_push_only_when_free) else $error("result overwritten");

  property p_freed_is_ok;
    @(posedge clk_i) disable iff (!rst_ni)
      (rsp_valid_o && rsp_o.entry_freed) |-> (rsp_o.status == StOk);
  endproperty
  assert property (p_freed_is_ok) else $error("freed with bad status");

endmodule

// ===== src/rclpt_hash.sv =====
// ----------------------------------------------------------------------------
// rclpt_hash
// Multi-cycle murmur3 64-bit finalizer. Each 64x64 product is split into
// 32x32 partial products, one per cycle, and accumulated.
// ----------------------------------------------------------------------------
module rclpt_hash import rclpt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  hash_req_t req_i,
  output hash_rsp_t rsp_o
);

  localparam logic [3:0] HsIdle = 4'd0;
  localparam logic [3:0] HsM0   = 4'd1;
  localparam logic [3:0] HsM1   = 4'd2;
  localparam logic [3:0] HsM2   = 4'd3;
  localparam logic [3:0] HsX1   = 4'd4;
  localparam logic [3:0] HsN0   = 4'd5;
  localparam logic [3:0] HsN1   = 4'd6;
  localparam logic [3:0] HsN2   = 4'd7;
  localparam logic [3:0] HsDone = 4'd8;

  logic [3:0]  state_q, state_d;
  logic [63:0] val_q, val_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [63:0] mconst;

  assign mconst = (state_q == HsN0 || state_q == HsN1 || state_q == HsN2) ?
                  HashMulB : HashMulA;

  always_comb begin
    mul_a = val_q[31:0];
    mul_b = mconst[31:0];
    case (state_q)
      HsM1, HsN1: begin
        mul_a = val_q[31:0];
        mul_b = mconst[63:32];
      end
      HsM2, HsN2: begin
        mul_a = val_q[63:32];
        mul_b = mconst[31:0];
      end
      default: begin
        mul_a = val_q[31:0];
        mul_b = mconst[31:0];
      end
    endcase
  end

  assign prod = {32'd0, mul_a} * {32'd0, mul_b};

  always_comb begin
    state_d = state_q;
    val_d   = val_q;
    acc_d   = acc_q;
    case (state_q)
      HsIdle: begin
        if (req_i.start) begin
          val_d   = req_i.key ^ (req_i.key >> HashShift);
          state_d = HsM0;
        end
      end
      HsM0, HsN0: begin
        acc_d   = prod;
        state_d = state_q + 4'd1;
      end
      HsM1, HsN1: begin
        acc_d   = acc_q + {prod[31:0], 32'd0};
        state_d = state_q + 4'd1;
      end
      HsM2: begin
        val_d   = acc_q + {prod[31:0], 32'd0};
        state_d = HsX1;
      end
      HsX1: begin
        val_d   = val_q ^ (val_q >> HashShift);
        state_d = HsN0;
      end
      HsN2: begin
        val_d   = acc_q + {prod[31:0], 32'd0};
        val_d   = val_d ^ (val_d >> HashShift);
        state_d = HsDone;
      end
      HsDone: begin
        state_d = HsIdle;
      end
      default: begin
        state_d = HsIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= HsIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    acc_q <= acc_d;
  end

  assign rsp_o.done = (state_q == HsDone);
  assign rsp_o.home = val_q[SlotBits-1:0];

endmodule
